>>> rtl/necir_pkg.sv
// ============================================================================
// necir_pkg - shared types and constants of the NEC IR frame decoder
// Register indexes, result codes, the classified event record and the
// helper that tests a duration against a nominal length.
// ============================================================================
package necir_pkg;

  // data bits in one full frame
  localparam int FRAME_BITS = 32;
  localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);

  // field widths
  localparam int DUR_W  = 16;
  localparam int UNIT_W = 12;
  localparam int TOL_W  = 12;
  localparam int TMO_W  = 16;
  // room for a nominal length plus tolerance
  localparam int CMP_W  = DUR_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TMO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TMO  = 2'd3;

  // reset values of the configuration registers
  localparam logic [UNIT_W-1:0] UNIT_RST    = 12'd563;
  localparam logic [TOL_W-1:0]  TOL_RST     = 12'd281;
  localparam logic [TMO_W-1:0]  GAP_TMO_RST = 16'd10000;
  localparam logic [TMO_W-1:0]  END_TMO_RST = 16'd1000;

  // event queue between classifier and sequencer
  localparam int QDEPTH  = 2;
  localparam int Q_PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int Q_CNT_W = $clog2(QDEPTH + 1);

  // result status codes
  typedef enum logic [1:0] {
    ST_FRAME  = 2'd0,
    ST_REPEAT = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  // one classified level event
  typedef struct packed {
    logic level;     // 0 low pulse, 1 high space
    logic m1;        // near 1 unit
    logic m3;        // near 3 units
    logic m4;        // near 4 units
    logic m8;        // near 8 units
    logic m16;       // near 16 units
    logic over_gap;  // wait beyond gap timeout
    logic over_end;  // wait beyond end pulse timeout
  } event_t;

  // nom - tol < dur < nom + tol, rearranged to stay unsigned
  function automatic logic near_len(input logic [DUR_W-1:0] dur,
                                    input logic [CMP_W-1:0] nom,
                                    input logic [TOL_W-1:0] tol);
    logic [CMP_W-1:0] dur_x;
    logic [CMP_W-1:0] tol_x;
    dur_x = CMP_W'(dur);
    tol_x = CMP_W'(tol);
    return ((dur_x + tol_x) > nom) && (dur_x < (nom + tol_x));
  endfunction

endpackage

>>> rtl/necir_classifier.sv
// ============================================================================
// necir_classifier - front end of the decoder
// Holds the configuration registers and tags each incoming level event
// with its length matches and timeout flags.
// ============================================================================
module necir_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [necir_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [necir_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                level_i,
  input  logic [necir_pkg::DUR_W-1:0]         duration_us_i,
  input  logic [necir_pkg::TMO_W-1:0]         wait_us_i,
  output necir_pkg::event_t                   event_o
);

  logic [necir_pkg::UNIT_W-1:0] unit_q;
  logic [necir_pkg::TOL_W-1:0]  tol_q;
  logic [necir_pkg::TMO_W-1:0]  gap_tmo_q;
  logic [necir_pkg::TMO_W-1:0]  end_tmo_q;

  logic [necir_pkg::CMP_W-1:0] nom1, nom3, nom4, nom8, nom16;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q    <= necir_pkg::UNIT_RST;
      tol_q     <= necir_pkg::TOL_RST;
      gap_tmo_q <= necir_pkg::GAP_TMO_RST;
      end_tmo_q <= necir_pkg::END_TMO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        necir_pkg::CFG_UNIT:    unit_q    <= cfg_data_i[necir_pkg::UNIT_W-1:0];
        necir_pkg::CFG_TOL:     tol_q     <= cfg_data_i[necir_pkg::TOL_W-1:0];
        necir_pkg::CFG_GAP_TMO: gap_tmo_q <= cfg_data_i[necir_pkg::TMO_W-1:0];
        necir_pkg::CFG_END_TMO: end_tmo_q <= cfg_data_i[necir_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // nominal lengths: shifts and one add
  assign nom1  = necir_pkg::CMP_W'(unit_q);
  assign nom3  = (nom1 << 1) + nom1;
  assign nom4  = nom1 << 2;
  assign nom8  = nom1 << 3;
  assign nom16 = nom1 << 4;

  // tag the event
  always_comb begin
    event_o.level    = level_i;
    event_o.m1       = necir_pkg::near_len(duration_us_i, nom1, tol_q);
    event_o.m3       = necir_pkg::near_len(duration_us_i, nom3, tol_q);
    event_o.m4       = necir_pkg::near_len(duration_us_i, nom4, tol_q);
    event_o.m8       = necir_pkg::near_len(duration_us_i, nom8, tol_q);
    event_o.m16      = necir_pkg::near_len(duration_us_i, nom16, tol_q);
    event_o.over_gap = wait_us_i > gap_tmo_q;
    event_o.over_end = wait_us_i > end_tmo_q;
  end

endmodule

>>> rtl/necir_queue.sv
// ============================================================================
// necir_queue - short event queue
// Small FIFO of classified events between the classifier and the
// sequencer; push and pop may happen in the same cycle.
// ============================================================================
module necir_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  necir_pkg::event_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output necir_pkg::event_t pop_data_o,
  output logic              valid_o
);

  necir_pkg::event_t                mem_q [necir_pkg::QDEPTH];
  logic [necir_pkg::Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [necir_pkg::Q_CNT_W-1:0]    cnt_q;

  logic do_push, do_pop;

  assign full_o     = cnt_q == necir_pkg::Q_CNT_W'(necir_pkg::QDEPTH);
  assign valid_o    = cnt_q != '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [necir_pkg::Q_PTR_W-1:0] ptr_inc(
      input logic [necir_pkg::Q_PTR_W-1:0] p);
    return (p == necir_pkg::Q_PTR_W'(necir_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/necir_sequencer.sv
// ============================================================================
// necir_sequencer - back end of the decoder
// Walks the NEC frame structure one classified event per cycle while the
// result slot is free or draining, and drives the result register.
// ============================================================================
module necir_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ev_valid_i,
  input  necir_pkg::event_t ev_i,
  output logic              ev_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [7:0]        address_o,
  output logic [7:0]        command_o
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_HIGH  = 3'd1,
    PH_REPEAT_END = 3'd2,
    PH_BIT_LOW    = 3'd3,
    PH_BIT_HIGH   = 3'd4,
    PH_FRAME_END  = 3'd5
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [necir_pkg::BIT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [necir_pkg::FRAME_BITS-1:0]  word_q, word_d;

  logic                 out_valid_q;
  necir_pkg::status_e   status_q, status_d;
  logic [7:0]           addr_q, addr_d, cmd_q, cmd_d;

  logic take, emit, leader, timeout, bit_one, bit_zero, low1;

  // step when an event waits and the result slot is free or draining
  assign take     = ev_valid_i && (!out_valid_q || out_ready_i);
  assign ev_pop_o = take;

  assign leader   = !ev_i.level && ev_i.m16;
  assign low1     = !ev_i.level && ev_i.m1;
  assign bit_one  = ev_i.level && ev_i.m3;
  assign bit_zero = ev_i.level && ev_i.m1;
  assign timeout  = (phase_q == PH_REPEAT_END || phase_q == PH_FRAME_END) ?
                    ev_i.over_end : ev_i.over_gap;

  // next phase and result
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    word_d   = word_q;
    emit     = 1'b0;
    status_d = necir_pkg::ST_ERROR;
    addr_d   = '0;
    cmd_d    = '0;
    if (phase_q != PH_IDLE && phase_q <= PH_FRAME_END && timeout) begin
      // late event: report, then judge it as a leader
      emit    = 1'b1;
      phase_d = leader ? PH_LEAD_HIGH : PH_IDLE;
    end else begin
      unique case (phase_q)
        PH_LEAD_HIGH: begin
          if (ev_i.level && ev_i.m4) begin
            phase_d = PH_REPEAT_END;
          end else if (ev_i.level && ev_i.m8) begin
            phase_d = PH_BIT_LOW;
            cnt_d   = '0;
            word_d  = '0;
          end else begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_REPEAT_END: begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
          if (low1) status_d = necir_pkg::ST_REPEAT;
        end
        PH_BIT_LOW: begin
          if (low1) begin
            phase_d = PH_BIT_HIGH;
          end else begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_BIT_HIGH: begin
          if (bit_one || bit_zero) begin
            // LSB first: after a full frame bit i sits at position i
            word_d  = {bit_one, word_q[necir_pkg::FRAME_BITS-1:1]};
            cnt_d   = cnt_q + 1'b1;
            phase_d = (cnt_d >= necir_pkg::BIT_CNT_W'(necir_pkg::FRAME_BITS)) ?
                      PH_FRAME_END : PH_BIT_LOW;
          end else begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_FRAME_END: begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
          // command byte must be the inverse of its complement byte
          if (low1 && (word_q[23:16] == ~word_q[31:24])) begin
            status_d = necir_pkg::ST_FRAME;
            addr_d   = word_q[7:0];
            cmd_d    = word_q[23:16];
          end
        end
        default: begin
          // idle and unused codes: only a leader is welcome
          if (leader) begin
            phase_d = PH_LEAD_HIGH;
          end else begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= necir_pkg::ST_ERROR;
      addr_q      <= '0;
      cmd_q       <= '0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        word_q  <= word_d;
      end
      if (take && emit) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        addr_q      <= addr_d;
        cmd_q       <= cmd_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign address_o   = addr_q;
  assign command_o   = cmd_q;

endmodule

>>> rtl/nec_ir_frame_decoder_core.sv
// ============================================================================
// nec_ir_frame_decoder_core - NEC infrared frame decoder
// Decodes leader, repeat code and 32-bit frames from timed level events.
// ============================================================================
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ------------------------------
//  in        sink       in_valid_i/in_ready_o   level_i, duration_us_i, wait_us_i
//  out       source     out_valid_o/out_ready_i status_o, address_o, command_o
//  cfg       sink       cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
//  One event per cycle sustained while results drain; an accepted event is
//  classified on the way into the queue, then one sequencer step takes it
//  into the result register behind out_valid_o. The sequencer step sets the rate.
//  Reset returns the registers to their defaults and the decoder to idle.
//  A stalled result holds the sequencer; the two-entry queue takes events
//  until it is full, then in_ready_o drops.
//
module nec_ir_frame_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [necir_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [necir_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              level_i,
  input  logic [15:0]                       duration_us_i,
  input  logic [15:0]                       wait_us_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [7:0]                        address_o,
  output logic [7:0]                        command_o
);

  necir_pkg::event_t ev_in, ev_head;
  logic q_full, q_valid, q_pop, push;

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && in_ready_o;

  // front: configuration and event tagging
  necir_classifier u_classifier (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .level_i       (level_i),
    .duration_us_i (duration_us_i),
    .wait_us_i     (wait_us_i),
    .event_o       (ev_in)
  );

  // queue between front and back
  necir_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (ev_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (ev_head),
    .valid_o     (q_valid)
  );

  // back: frame sequencer and result register
  necir_sequencer u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (q_valid),
    .ev_i        (ev_head),
    .ev_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .address_o   (address_o),
    .command_o   (command_o)
  );

  // a request pushed into an empty queue is there next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_valid) |=> q_valid)
    else $error("queued request lost");

  // the sequencer never pops an empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // only a full frame carries address and command
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != necir_pkg::ST_FRAME) |->
      (address_o == 8'd0 && command_o == 8'd0))
    else $error("payload on non-frame result");

endmodule
